FILE: hdl/gcr_pkg.sv
// Shared types and constants for the glyph column renderer.
// Holds command codes, display write kinds and the queue entry type.
// No dependencies.
package gcr_pkg;

    // Width of raw font addresses before reduction to the memory depth
    localparam int RAW_W = 16;

    // Entries in the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Input operation codes
    typedef logic [1:0] t_op;
    localparam t_op OP_LOAD  = 2'd0;
    localparam t_op OP_DRAW  = 2'd1;
    localparam t_op OP_GOTO  = 2'd2;
    localparam t_op OP_SPACE = 2'd3;

    // Classified command codes
    typedef logic [2:0] t_cmd_kind;
    localparam t_cmd_kind CMD_LOAD  = 3'd0;
    localparam t_cmd_kind CMD_DRAW  = 3'd1;
    localparam t_cmd_kind CMD_GOTO  = 3'd2;
    localparam t_cmd_kind CMD_SPACE = 3'd3;
    localparam t_cmd_kind CMD_NOP   = 3'd4;

    // Display write kinds
    typedef logic [1:0] t_wkind;
    localparam t_wkind KIND_DATA = 2'd0;
    localparam t_wkind KIND_PAGE = 2'd1;
    localparam t_wkind KIND_COL  = 2'd2;

    // Printable character range and font header layout
    localparam logic [7:0] CHAR_FIRST     = 8'd32;
    localparam logic [7:0] CHAR_END       = 8'd128;
    localparam logic [7:0] HDR_HEIGHT_OFS = 8'd2;
    localparam logic [7:0] GLYPH_OFS      = 8'd3;

    // One queued command
    typedef struct packed {
        t_cmd_kind   kind;
        logic [11:0] addr;   // load address
        logic [7:0]  arg;    // load byte, glyph index or goto column
        logic [2:0]  line;   // goto page
        logic [1:0]  pages;  // spacer page count
    } t_cmd;

    // Queue head as seen by the back part
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

endpackage

FILE: hdl/gcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the font memory. No dependencies.
module gcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/gcr_modred.sv
// Reduction of a raw font address modulo the font memory depth.
// Reciprocal multiply, then one correcting subtract; the estimate is registered
// first, then the reduced result together with done. Uses gcr_pkg.
module gcr_modred #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [gcr_pkg::RAW_W-1:0] i_value,
    output logic                     o_done,
    output logic [$clog2(DEPTH)-1:0] o_result
);
    import gcr_pkg::*;

    // DEPTH is at least 256, so the reciprocal fits nine bits and the
    // estimated quotient falls short of the true one by at most one
    localparam int AW = $clog2(DEPTH);
    localparam int RW = 9;
    localparam int PW = RAW_W + RW;
    localparam int DW = RAW_W + 1;
    localparam logic [RW-1:0] RECIP = RW'((1 << RAW_W) / DEPTH);

    logic [RAW_W-1:0] r_val;
    logic [RW-1:0]    r_quo;
    logic             r_run;
    logic             r_done;
    logic [AW-1:0]    r_res;
    logic [PW-1:0]    w_prod;
    logic [DW-1:0]    w_back;
    logic [DW-1:0]    w_rem;
    logic [DW-1:0]    w_fix;

    // Estimate the quotient from the reciprocal
    assign w_prod = PW'(i_value) * PW'(RECIP);

    // Remove the estimated multiple, then correct a quotient that is one short
    assign w_back = DW'(r_quo) * DW'(DEPTH);
    assign w_rem  = DW'(r_val) - w_back;
    assign w_fix  = (w_rem >= DW'(DEPTH)) ? w_rem - DW'(DEPTH) : w_rem;

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= i_start;
            r_done <= r_run;
        end
    end

    // Capture the value and estimate, then the reduced result
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_quo <= w_prod[PW-1:RAW_W];
        end
        if (r_run) begin
            r_res <= w_fix[AW-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

FILE: hdl/gcr_front.sv
// Front part: accepts input beats, classifies them into commands and
// queues them for the back part. Uses gcr_pkg.
module gcr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_operation,
    input  logic [11:0]        i_font_addr,
    input  logic [7:0]         i_font_byte,
    input  logic [7:0]         i_char_code,
    input  logic [7:0]         i_column,
    input  logic [2:0]         i_line,
    input  logic [7:0]         i_spacer_height,
    output gcr_pkg::t_qhead    o_head,
    input  logic               i_pop
);
    import gcr_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [QAW-1:0]   r_wptr;
    logic [QAW-1:0]   r_rptr;
    logic [QAW:0]     r_count;
    logic             w_full;
    logic             w_push;
    t_cmd             w_cmd;

    assign w_full = (r_count == (QAW + 1)'(QUEUE_DEPTH));
    assign w_push = i_start && !w_full;

    // Classify the incoming beat
    always_comb begin
        w_cmd       = '0;
        w_cmd.kind  = CMD_NOP;
        w_cmd.addr  = i_font_addr;
        w_cmd.line  = i_line;
        unique case (i_operation)
            OP_LOAD: begin
                w_cmd.kind = CMD_LOAD;
                w_cmd.arg  = i_font_byte;
            end
            OP_DRAW: begin
                // drop codes outside the printable range
                if (i_char_code >= CHAR_FIRST && i_char_code < CHAR_END) begin
                    w_cmd.kind = CMD_DRAW;
                    w_cmd.arg  = i_char_code - CHAR_FIRST;
                end
            end
            OP_GOTO: begin
                w_cmd.kind = CMD_GOTO;
                w_cmd.arg  = i_column;
            end
            OP_SPACE: begin
                w_cmd.kind  = CMD_SPACE;
                w_cmd.pages = (i_spacer_height > 8'd16) ? 2'd3 :
                              (i_spacer_height > 8'd8)  ? 2'd2 : 2'd1;
            end
        endcase
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_cmd;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + (QAW + 1)'(w_push) - (QAW + 1)'(i_pop);
        end
    end

    assign o_busy       = w_full;
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rptr];

endmodule

FILE: hdl/gcr_back.sv
// Back part: sequences queued commands into display writes, owns the
// font memory and the cursor. Uses gcr_pkg, gcr_ram and gcr_modred.
module gcr_back #(
    parameter int FONT_DEPTH      = 4096,
    parameter int MAX_GLYPH_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [11:0]     i_font_base,
    input  gcr_pkg::t_qhead i_head,
    output logic            o_pop,
    output logic            o_valid,
    output logic [1:0]      o_write_kind,
    output logic [7:0]      o_write_value,
    output logic            o_last
);
    import gcr_pkg::*;

    localparam int AW = $clog2(FONT_DEPTH);
    localparam int WW = $clog2(MAX_GLYPH_WIDTH + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_HB   = 4'd2;
    localparam logic [3:0] S_HBD  = 4'd3;
    localparam logic [3:0] S_HH   = 4'd4;
    localparam logic [3:0] S_HHD  = 4'd5;
    localparam logic [3:0] S_GW   = 4'd6;
    localparam logic [3:0] S_GWD  = 4'd7;
    localparam logic [3:0] S_PAGE = 4'd8;
    localparam logic [3:0] S_COLC = 4'd9;
    localparam logic [3:0] S_DRD  = 4'd10;
    localparam logic [3:0] S_DOUT = 4'd11;
    localparam logic [3:0] S_GAP  = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;
    localparam logic [3:0] S_GCOL = 4'd14;

    // Add a small step to a font address, wrapping at the depth
    function automatic logic [AW-1:0] f_wrap_add(input logic [AW-1:0] a,
                                                 input logic [5:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + (AW + 1)'(b);
        if (s >= (AW + 1)'(FONT_DEPTH)) begin
            s = s - (AW + 1)'(FONT_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [3:0]    r_state,   n_state;
    logic [7:0]    r_arg,     n_arg;
    logic [7:0]    r_cur_col, n_cur_col;
    logic [2:0]    r_cur_page, n_cur_page;
    logic [7:0]    r_bpg,     n_bpg;
    logic [4:0]    r_stride,  n_stride;
    logic [1:0]    r_npages,  n_npages;
    logic [1:0]    r_p,       n_p;
    logic [WW-1:0] r_width,   n_width;
    logic [WW-1:0] r_k,       n_k;
    logic [AW-1:0] r_start,   n_start;
    logic [AW-1:0] r_idx,     n_idx;
    logic          r_out_valid, n_out_valid;
    t_wkind        r_out_kind,  n_out_kind;
    logic [7:0]    r_out_value, n_out_value;
    logic          r_out_last,  n_out_last;

    logic              w_mr_start;
    logic [RAW_W-1:0]  w_mr_value;
    logic              w_mr_done;
    logic [AW-1:0]     w_mr_result;
    logic              w_ram_we;
    logic [AW-1:0]     w_ram_raddr;
    logic [7:0]        w_ram_rdata;
    logic [14:0]       w_prod;
    logic [4:0]        w_hpages;
    logic [WW-1:0]     w_clip;
    logic [2:0]        w_pg;

    gcr_modred #(
        .DEPTH (FONT_DEPTH)
    ) u_modred (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mr_start),
        .i_value  (w_mr_value),
        .o_done   (w_mr_done),
        .o_result (w_mr_result)
    );

    gcr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_mr_result),
        .i_wdata (r_arg),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Glyph offset, header page count and clipped width
    assign w_prod   = 15'(r_arg[6:0]) * 15'(r_bpg);
    assign w_hpages = w_ram_rdata[7:3];
    assign w_clip   = (w_ram_rdata > 8'(MAX_GLYPH_WIDTH)) ? WW'(MAX_GLYPH_WIDTH)
                                                          : WW'(w_ram_rdata);
    assign w_pg     = r_cur_page + 3'(r_p);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_arg       = r_arg;
        n_cur_col   = r_cur_col;
        n_cur_page  = r_cur_page;
        n_bpg       = r_bpg;
        n_stride    = r_stride;
        n_npages    = r_npages;
        n_p         = r_p;
        n_width     = r_width;
        n_k         = r_k;
        n_start     = r_start;
        n_idx       = r_idx;
        n_out_valid = 1'b0;
        n_out_kind  = KIND_DATA;
        n_out_value = '0;
        n_out_last  = 1'b0;
        o_pop       = 1'b0;
        w_mr_start  = 1'b0;
        w_mr_value  = '0;
        w_ram_we    = 1'b0;
        w_ram_raddr = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    n_arg = i_head.cmd.arg;
                    unique case (i_head.cmd.kind)
                        CMD_LOAD: begin
                            w_mr_start = 1'b1;
                            w_mr_value = RAW_W'(i_head.cmd.addr);
                            n_state    = S_LOAD;
                        end
                        CMD_DRAW: begin
                            w_mr_start = 1'b1;
                            w_mr_value = RAW_W'(i_font_base);
                            n_state    = S_HB;
                        end
                        CMD_GOTO: begin
                            n_cur_col   = i_head.cmd.arg;
                            n_cur_page  = i_head.cmd.line;
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_PAGE;
                            n_out_value = 8'(i_head.cmd.line);
                            n_state     = S_GCOL;
                        end
                        CMD_SPACE: begin
                            n_width  = '0;
                            n_npages = i_head.cmd.pages;
                            n_p      = '0;
                            n_state  = S_GAP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                // write once the address is reduced
                if (w_mr_done) begin
                    w_ram_we = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_HB: begin
                if (w_mr_done) begin
                    w_ram_raddr = w_mr_result;
                    n_state     = S_HBD;
                end
            end
            S_HBD: begin
                n_bpg      = w_ram_rdata;
                w_mr_start = 1'b1;
                w_mr_value = RAW_W'(i_font_base) + RAW_W'(HDR_HEIGHT_OFS);
                n_state    = S_HH;
            end
            S_HH: begin
                if (w_mr_done) begin
                    w_ram_raddr = w_mr_result;
                    n_state     = S_HHD;
                end
            end
            S_HHD: begin
                n_stride   = w_hpages;
                n_npages   = (w_hpages >= 5'd3) ? 2'd3 :
                             (w_hpages == 5'd2) ? 2'd2 : 2'd1;
                w_mr_start = 1'b1;
                w_mr_value = RAW_W'(i_font_base) + RAW_W'(GLYPH_OFS) + RAW_W'(w_prod);
                n_state    = S_GW;
            end
            S_GW: begin
                // read the width byte; column data starts right after it
                if (w_mr_done) begin
                    w_ram_raddr = w_mr_result;
                    n_start     = f_wrap_add(w_mr_result, 6'd1);
                    n_idx       = f_wrap_add(w_mr_result, 6'd1);
                    n_state     = S_GWD;
                end
            end
            S_GWD: begin
                n_width = w_clip;
                n_p     = '0;
                n_state = (w_clip == '0) ? S_GAP : S_DRD;
            end
            S_PAGE: begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_PAGE;
                n_out_value = 8'(w_pg);
                n_state     = S_COLC;
            end
            S_COLC: begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_COL;
                n_out_value = r_cur_col;
                n_state     = (r_width == '0) ? S_GAP : S_DRD;
            end
            S_DRD: begin
                // first column read of this page
                w_ram_raddr = r_idx;
                n_idx       = f_wrap_add(r_idx, {1'b0, r_stride});
                n_k         = WW'(1);
                n_state     = S_DOUT;
            end
            S_DOUT: begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_DATA;
                n_out_value = w_ram_rdata;
                if (r_k == r_width) begin
                    n_state = S_GAP;
                end else begin
                    w_ram_raddr = r_idx;
                    n_idx       = f_wrap_add(r_idx, {1'b0, r_stride});
                    n_k         = r_k + 1'b1;
                end
            end
            S_GAP: begin
                // blank spacing column, then next page or finish
                n_out_valid = 1'b1;
                n_out_kind  = KIND_DATA;
                n_out_value = '0;
                if ((r_p + 2'd1) < r_npages) begin
                    n_p     = r_p + 2'd1;
                    n_idx   = f_wrap_add(r_start, 6'(r_p + 2'd1));
                    n_state = S_PAGE;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_PAGE;
                n_out_value = 8'(r_cur_page);
                n_out_last  = 1'b1;
                n_cur_col   = r_cur_col + 8'(r_width) + 8'd1;
                n_state     = S_IDLE;
            end
            S_GCOL: begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_COL;
                n_out_value = r_cur_col;
                n_out_last  = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_col   <= '0;
            r_cur_page  <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_col   <= n_cur_col;
            r_cur_page  <= n_cur_page;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_arg       <= n_arg;
        r_bpg       <= n_bpg;
        r_stride    <= n_stride;
        r_npages    <= n_npages;
        r_p         <= n_p;
        r_width     <= n_width;
        r_k         <= n_k;
        r_start     <= n_start;
        r_idx       <= n_idx;
        r_out_kind  <= n_out_kind;
        r_out_value <= n_out_value;
    end

    assign o_valid       = r_out_valid;
    assign o_write_kind  = r_out_kind;
    assign o_write_value = r_out_value;
    assign o_last        = r_out_last;

endmodule

FILE: hdl/glyph_column_renderer.sv
// Top level of the glyph column renderer: font base register, front part
// and back part. Depends on gcr_pkg, gcr_front and gcr_back.
//
// Usage: raise start with the input fields; the beat is taken at a clock
// edge where busy is low. A two-entry command queue sits between the
// accepting front and the executing back, so busy rises only when two
// commands are waiting. Display writes leave on o_write_kind/o_write_value
// with o_valid high for one cycle each; o_last marks the final write of a
// command. The receiver cannot stall: one write is produced per cycle while
// a page is drawn.
// Each draw spends its setup on three font address reductions in the shared
// modulo unit and on the registered reads of the font RAM. font_base is
// written through i_font_base_we; the user must write it only while the
// block is idle, and the block itself does not enforce this.
// Reset clears the cursor to column 0, page 0, the font base to 0 and
// empties the queue; font memory contents are undefined until loaded.
module glyph_column_renderer #(
    parameter int FONT_DEPTH      = 4096,
    parameter int MAX_GLYPH_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_font_base_we,
    input  logic [11:0] i_font_base,
    input  logic [1:0]  i_operation,
    input  logic [11:0] i_font_addr,
    input  logic [7:0]  i_font_byte,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_column,
    input  logic [2:0]  i_line,
    input  logic [7:0]  i_spacer_height,
    output logic        o_valid,
    output logic [1:0]  o_write_kind,
    output logic [7:0]  o_write_value,
    output logic        o_last
);
    import gcr_pkg::*;

    logic [11:0] r_font_base;
    t_qhead      w_head;
    logic        w_pop;

    // Font base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_base <= '0;
        end else if (i_font_base_we) begin
            r_font_base <= i_font_base;
        end
    end

    gcr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_operation     (i_operation),
        .i_font_addr     (i_font_addr),
        .i_font_byte     (i_font_byte),
        .i_char_code     (i_char_code),
        .i_column        (i_column),
        .i_line          (i_line),
        .i_spacer_height (i_spacer_height),
        .o_head          (w_head),
        .i_pop           (w_pop)
    );

    gcr_back #(
        .FONT_DEPTH      (FONT_DEPTH),
        .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_font_base   (r_font_base),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .o_write_kind  (o_write_kind),
        .o_write_value (o_write_value),
        .o_last        (o_last)
    );

    // Every command that writes ends on an address command, never on a data byte
    a_last_is_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_write_kind != KIND_DATA)
        else $error("final write of a command is a data byte");

    // The back part only pops a queue that holds a command
    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("pop from an empty command queue");

    // A full queue always presents a command to the back part
    a_busy_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> w_head.valid)
        else $error("busy with no queued command");

endmodule

FILE: tb/glyph_write_checker.sv
`timescale 1ns / 1ps
// Checker for the glyph column renderer: mirrors font memory, cursor and
// font base, predicts the display writes of every accepted beat and compares
// them with the write channel. Depends on gcr_pkg.
module glyph_write_checker #(
    parameter int FONT_DEPTH      = 4096,
    parameter int MAX_GLYPH_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  logic            i_font_base_we,
    input  logic [11:0]     i_font_base,
    input  gcr_pkg::t_op    i_operation,
    input  logic [11:0]     i_font_addr,
    input  logic [7:0]      i_font_byte,
    input  logic [7:0]      i_char_code,
    input  logic [7:0]      i_column,
    input  logic [2:0]      i_line,
    input  logic [7:0]      i_spacer_height,
    input  logic            i_valid,
    input  gcr_pkg::t_wkind i_write_kind,
    input  logic [7:0]      i_write_value,
    input  logic            i_last,
    output int              o_fail_count,
    output int              o_pending
);
    import gcr_pkg::*;

    typedef struct packed {
        t_wkind     kind;
        logic [7:0] value;
        logic       last;
    } t_lcd_write;

    t_lcd_write  expected_writes[$];
    logic [7:0]  font_mem [FONT_DEPTH];
    logic [7:0]  cur_col;
    logic [2:0]  cur_page;
    logic [11:0] font_base;
    int          item_writes;
    int          mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic logic [7:0] font_rd(input int addr);
        return font_mem[addr % FONT_DEPTH];
    endfunction

    task automatic queue_write(input t_wkind kind, input logic [7:0] value);
        t_lcd_write w;
        w.kind  = kind;
        w.value = value;
        w.last  = 1'b0;
        expected_writes.push_back(w);
        item_writes++;
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h",
                     $time, what, want, got);
            mismatches++;
        end
    endtask

    // Columns of every page, a blank spacing column, then back to the cursor page
    task automatic render_char(input logic [7:0] code);
        int         first;
        int         width;
        int         pages;
        int         idx;
        int         p;
        int         k;
        logic [2:0] page_no;
        if (code < CHAR_FIRST || code >= CHAR_END)
            return;
        first = int'(font_base) + int'(GLYPH_OFS) +
                (int'(code) - int'(CHAR_FIRST)) * int'(font_rd(int'(font_base)));
        width = int'(font_rd(first));
        if (width > MAX_GLYPH_WIDTH)
            width = MAX_GLYPH_WIDTH;
        first++;
        pages = int'(font_rd(int'(font_base) + int'(HDR_HEIGHT_OFS))) >> 3;
        for (p = 0; p < 3 && (p == 0 || pages > p); p++) begin
            if (p > 0) begin
                page_no = cur_page + 3'(p);
                queue_write(KIND_PAGE, {5'd0, page_no});
                queue_write(KIND_COL, cur_col);
            end
            idx = first + p;
            for (k = 0; k < width; k++) begin
                queue_write(KIND_DATA, font_rd(idx));
                idx += pages;
            end
            queue_write(KIND_DATA, 8'd0);
        end
        cur_col = cur_col + 8'(width + 1);
        queue_write(KIND_PAGE, {5'd0, cur_page});
    endtask

    // One blank column per page that the height reaches
    task automatic render_spacer(input logic [7:0] height);
        logic [2:0] page_no;
        queue_write(KIND_DATA, 8'd0);
        if (height > 8'd8) begin
            page_no = cur_page + 3'd1;
            queue_write(KIND_PAGE, {5'd0, page_no});
            queue_write(KIND_COL, cur_col);
            queue_write(KIND_DATA, 8'd0);
        end
        if (height > 8'd16) begin
            page_no = cur_page + 3'd2;
            queue_write(KIND_PAGE, {5'd0, page_no});
            queue_write(KIND_COL, cur_col);
            queue_write(KIND_DATA, 8'd0);
        end
        cur_col = cur_col + 8'd1;
        queue_write(KIND_PAGE, {5'd0, cur_page});
    endtask

    always @(posedge i_clk) begin
        t_lcd_write want;
        if (!i_rst_n) begin
            cur_col   = 8'd0;
            cur_page  = 3'd0;
            font_base = 12'd0;
            expected_writes.delete();
        end else begin
            // Compare each write beat against the oldest prediction
            if (i_valid === 1'b1) begin
                if (expected_writes.size() == 0) begin
                    $display("%0t: write mismatch, expected none, actual kind %0d value 0x%02h",
                             $time, i_write_kind, i_write_value);
                    mismatches++;
                end else begin
                    want = expected_writes.pop_front();
                    check_field("write_kind", {6'd0, want.kind}, {6'd0, i_write_kind});
                    check_field("write_value", want.value, i_write_value);
                    check_field("last", {7'd0, want.last}, {7'd0, i_last});
                end
            end

            if (i_font_base_we)
                font_base = i_font_base;

            // Predict the writes of an accepted command beat
            if (i_start && !i_busy) begin
                item_writes = 0;
                case (i_operation)
                    OP_LOAD: font_mem[int'(i_font_addr) % FONT_DEPTH] = i_font_byte;
                    OP_DRAW: render_char(i_char_code);
                    OP_GOTO: begin
                        cur_page = i_line;
                        cur_col  = i_column;
                        queue_write(KIND_PAGE, {5'd0, i_line});
                        queue_write(KIND_COL, i_column);
                    end
                    default: render_spacer(i_spacer_height);
                endcase
                if (item_writes > 0) begin
                    want = expected_writes.pop_back();
                    want.last = 1'b1;
                    expected_writes.push_back(want);
                end
            end
        end
        o_pending <= expected_writes.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the glyph column renderer: clock, reset, command beats,
// watchdog and verdict. Depends on gcr_pkg, glyph_column_renderer and
// glyph_write_checker.
module tb;
    import gcr_pkg::*;

    localparam int FONT_DEPTH      = 4096;
    localparam int MAX_GLYPH_WIDTH = 16;
    localparam int RANDOM_BEATS    = 270;
    localparam int PHASES          = 4;
    localparam int SETTLE_CYCLES   = 100;
    localparam int STALL_LIMIT     = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        font_base_we = 1'b0;
    logic [11:0] font_base = 12'd0;
    t_op         operation = OP_LOAD;
    logic [11:0] font_addr = 12'd0;
    logic [7:0]  font_byte = 8'd0;
    logic [7:0]  char_code = 8'd0;
    logic [7:0]  column = 8'd0;
    logic [2:0]  line = 3'd0;
    logic [7:0]  spacer_height = 8'd0;
    logic        valid;
    t_wkind      write_kind;
    logic [7:0]  write_value;
    logic        last;
    int          fail_count;
    int          pending;

    // Font image as loaded so far, used to plan loads ahead of each draw
    logic [7:0]  font_img [FONT_DEPTH];
    bit          font_known [FONT_DEPTH];
    logic [11:0] base_now = 12'd0;
    logic [7:0]  code_pool [5];
    int          idle_pct = 0;
    int          beats_sent = 0;
    int          stall_cycles = 0;

    glyph_column_renderer #(
        .FONT_DEPTH      (FONT_DEPTH),
        .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .start           (start),
        .busy            (busy),
        .i_font_base_we  (font_base_we),
        .i_font_base     (font_base),
        .i_operation     (operation),
        .i_font_addr     (font_addr),
        .i_font_byte     (font_byte),
        .i_char_code     (char_code),
        .i_column        (column),
        .i_line          (line),
        .i_spacer_height (spacer_height),
        .o_valid         (valid),
        .o_write_kind    (write_kind),
        .o_write_value   (write_value),
        .o_last          (last)
    );

    glyph_write_checker #(
        .FONT_DEPTH      (FONT_DEPTH),
        .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
    ) i_write_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_font_base_we  (font_base_we),
        .i_font_base     (font_base),
        .i_operation     (operation),
        .i_font_addr     (font_addr),
        .i_font_byte     (font_byte),
        .i_char_code     (char_code),
        .i_column        (column),
        .i_line          (line),
        .i_spacer_height (spacer_height),
        .i_valid         (valid),
        .i_write_kind    (write_kind),
        .i_write_value   (write_value),
        .i_last          (last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #1 clk = ~clk;

    // Abort when neither a command nor a write moves for too long
    always @(posedge clk) begin
        if ((start && !busy) || valid === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("glyph_column_renderer test failed");
            $finish;
        end
    end

    function automatic logic [7:0] pick_stride();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'd0;
        else if (r < 85)
            return 8'($urandom_range(1, 12));
        return 8'($urandom_range(13, 255));
    endfunction

    function automatic logic [7:0] pick_height();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return 8'($urandom_range(0, 7));
        else if (r < 45)
            return 8'($urandom_range(8, 15));
        else if (r < 70)
            return 8'($urandom_range(16, 23));
        else if (r < 92)
            return 8'($urandom_range(24, 31));
        return 8'($urandom_range(32, 255));
    endfunction

    function automatic logic [7:0] pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 8'($urandom_range(0, 4));
        else if (r < 95)
            return 8'($urandom_range(5, 16));
        return 8'($urandom_range(17, 255));
    endfunction

    function automatic logic [11:0] glyph_addr(input logic [7:0] code);
        return 12'(int'(base_now) + int'(GLYPH_OFS) +
                   (int'(code) - int'(CHAR_FIRST)) * int'(font_img[base_now]));
    endfunction

    // Drop start and hold it low for the pause given by n
    task automatic pause(input int n);
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Present one command beat, hold it until taken, then maybe go idle
    task automatic send_beat(input t_op op, input logic [11:0] addr,
                             input logic [7:0] data, input logic [7:0] code,
                             input logic [7:0] col, input logic [2:0] ln,
                             input logic [7:0] height);
        @(negedge clk);
        operation     = op;
        font_addr     = addr;
        font_byte     = data;
        char_code     = code;
        column        = col;
        line          = ln;
        spacer_height = height;
        start         = 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
        beats_sent++;
        if ($urandom_range(0, 99) < idle_pct)
            pause(($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(1, 3));
    endtask

    // Hold off until every predicted write is out, then let loads finish
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_font_base(input logic [11:0] value);
        @(negedge clk);
        font_base_we = 1'b1;
        font_base    = value;
        base_now     = value;
        @(negedge clk);
        font_base_we = 1'b0;
    endtask

    task automatic load_font_byte(input logic [11:0] addr, input logic [7:0] value);
        font_img[addr]   = value;
        font_known[addr] = 1'b1;
        send_beat(OP_LOAD, addr, value, 8'($urandom), 8'($urandom), 3'($urandom),
                  8'($urandom));
    endtask

    task automatic fill_if_unknown(input logic [11:0] addr, input logic [7:0] value);
        if (!font_known[addr])
            load_font_byte(addr, value);
    endtask

    task automatic goto_cell(input logic [7:0] col, input logic [2:0] ln);
        send_beat(OP_GOTO, 12'($urandom), 8'($urandom), 8'($urandom), col, ln,
                  8'($urandom));
    endtask

    task automatic add_spacer(input logic [7:0] height);
        send_beat(OP_SPACE, 12'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  3'($urandom), height);
    endtask

    // Load whatever the glyph still lacks, then draw it
    task automatic draw_code(input logic [7:0] code);
        logic [11:0] first;
        int          width;
        int          pages;
        int          p;
        int          k;
        if (code >= CHAR_FIRST && code < CHAR_END) begin
            fill_if_unknown(base_now, pick_stride());
            fill_if_unknown(base_now + 12'(HDR_HEIGHT_OFS), pick_height());
            first = glyph_addr(code);
            fill_if_unknown(first, pick_width());
            width = int'(font_img[first]);
            if (width > MAX_GLYPH_WIDTH)
                width = MAX_GLYPH_WIDTH;
            pages = int'(font_img[base_now + 12'(HDR_HEIGHT_OFS)]) >> 3;
            for (p = 0; p < 3 && (p == 0 || pages > p); p++)
                for (k = 0; k < width; k++)
                    fill_if_unknown(first + 12'(1 + p + k * pages), 8'($urandom));
        end
        send_beat(OP_DRAW, 12'($urandom), 8'($urandom), code, 8'($urandom),
                  3'($urandom), 8'($urandom));
    endtask

    initial begin
        int phase;
        int phase_end;
        int drain_at;
        int sel;
        bit drained;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed: top font base, edge cursor, spacer heights, odd codes
        write_font_base(12'hFFF);
        goto_cell(8'd250, 3'd7);
        add_spacer(8'd0);
        add_spacer(8'd8);
        add_spacer(8'd9);
        add_spacer(8'd16);
        add_spacer(8'd17);
        add_spacer(8'd255);
        draw_code(8'd0);
        draw_code(8'd31);
        draw_code(8'd128);
        draw_code(8'd255);
        // Header wraps to the bottom of memory; height below 8 draws one page
        load_font_byte(base_now, 8'd1);
        load_font_byte(base_now + 12'(HDR_HEIGHT_OFS), 8'd4);
        // Wide glyph clipped to the maximum width
        load_font_byte(glyph_addr(8'd127), 8'd255);
        draw_code(8'd127);
        draw_code(8'd32);
        load_font_byte(base_now + 12'(HDR_HEIGHT_OFS), 8'd16);
        draw_code(8'd33);
        load_font_byte(base_now + 12'(HDR_HEIGHT_OFS), 8'd24);
        draw_code(8'd32);
        goto_cell(8'd0, 3'd0);
        add_spacer(8'd9);

        // Random phases: fresh font header and glyph pool each time
        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: begin
                    idle_pct = 58;
                    write_font_base(12'd0);
                end
                1: begin
                    idle_pct = 24;
                    write_font_base(12'($urandom));
                end
                2: begin
                    idle_pct = 0;
                    write_font_base(12'h800);
                end
                default: begin
                    idle_pct = 58;
                    write_font_base(12'($urandom));
                end
            endcase
            load_font_byte(base_now, pick_stride());
            load_font_byte(base_now + 12'(HDR_HEIGHT_OFS), pick_height());
            foreach (code_pool[i])
                code_pool[i] = 8'($urandom_range(32, 127));
            phase_end = beats_sent + RANDOM_BEATS / PHASES;
            drain_at  = beats_sent + $urandom_range(10, 40);
            drained   = 1'b0;
            while (beats_sent < phase_end) begin
                if (!drained && beats_sent >= drain_at) begin
                    drain();
                    drained = 1'b1;
                end
                sel = $urandom_range(0, 99);
                if (sel < 48)
                    draw_code(code_pool[$urandom_range(0, 4)]);
                else if (sel < 54)
                    draw_code(8'($urandom));
                else if (sel < 62)
                    draw_code($urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                   : 8'($urandom_range(128, 255)));
                else if (sel < 74)
                    goto_cell(8'($urandom), 3'($urandom));
                else if (sel < 86)
                    add_spacer($urandom_range(0, 1) ? 8'($urandom_range(0, 24))
                                                    : 8'($urandom));
                else if (sel < 95)
                    load_font_byte(12'($urandom), 8'($urandom));
                else
                    load_font_byte(base_now + 12'(HDR_HEIGHT_OFS), pick_height());
            end
        end

        drain();
        if (fail_count == 0)
            $display("glyph_column_renderer test passed");
        else
            $display("glyph_column_renderer test failed");
        $finish;
    end

endmodule
